>>> rtl/core/mpotl_pkg.sv
package mpotl_pkg;

  localparam int LEN_W      = 12;
  localparam int ENTRY_W    = LEN_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_LENGTH_DEF = 4095;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_LEN_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_LEN_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_LEN_C = 2'd2;

  // Table entry: bit 12 marks a reachable length, bits 11..0 the count
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam entry_t ENTRY_ZERO_LEN = {1'b1, {LEN_W{1'b0}}};

  typedef struct packed {
    logic              idle;
    logic              res_valid;
    logic [LEN_W-1:0]  res_count;
    logic              res_possible;
  } eng_stat_t;

  // Entry reached by one more piece from prev; zero when not usable or prev is unreachable
  function automatic entry_t cand(input logic usable, input entry_t prev);
    entry_t r;
    r = '0;
    if (usable && prev[LEN_W]) begin
      r = {1'b1, prev[LEN_W-1:0] + LEN_W'(1)};
    end
    return r;
  endfunction

  function automatic entry_t max3(input entry_t a, input entry_t b, input entry_t c);
    entry_t m;
    m = a;
    if (b > m) begin
      m = b;
    end
    if (c > m) begin
      m = c;
    end
    return m;
  endfunction

endpackage

>>> rtl/core/mpotl_table_ram.sv
module mpotl_table_ram #(
  parameter int MAX_LENGTH = mpotl_pkg::MAX_LENGTH_DEF,
  parameter int AW = $clog2(MAX_LENGTH + 1)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  mpotl_pkg::entry_t  wdata,
  input  logic [AW-1:0]      raddr,
  output mpotl_pkg::entry_t  rdata
);

  mpotl_pkg::entry_t mem [0:MAX_LENGTH];
  mpotl_pkg::entry_t rdata_r;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mpotl_engine.sv
module mpotl_engine #(
  parameter int MAX_LENGTH = mpotl_pkg::MAX_LENGTH_DEF,
  parameter int AW = $clog2(MAX_LENGTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mpotl_pkg::LEN_W-1:0]   target,
  input  logic [mpotl_pkg::LEN_W-1:0]   len_a,
  input  logic [mpotl_pkg::LEN_W-1:0]   len_b,
  input  logic [mpotl_pkg::LEN_W-1:0]   len_c,
  input  logic                          res_take,
  output mpotl_pkg::eng_stat_t          stat,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output mpotl_pkg::entry_t             mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  mpotl_pkg::entry_t             mem_rdata
);

  localparam int LW = mpotl_pkg::LEN_W;

  typedef enum logic [1:0] {IDLE, FILL, FINISH, DONE} state_t;
  typedef enum logic [1:0] {PH_A, PH_B, PH_C} phase_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      tgt_r, tgt_nxt;
  logic               use_r, use_nxt;
  mpotl_pkg::entry_t  cand_a_r, cand_a_nxt;
  mpotl_pkg::entry_t  cand_b_r, cand_b_nxt;
  logic               fwd_valid_r, fwd_valid_nxt;
  mpotl_pkg::entry_t  fwd_data_r, fwd_data_nxt;
  logic [LW-1:0]      count_r, count_nxt;
  logic               possible_r, possible_nxt;

  logic [LW-1:0]      piece;
  logic [LW-1:0]      diff;
  logic               usable;
  mpotl_pkg::entry_t  best;
  mpotl_pkg::entry_t  src;
  logic               in_range;

  always_comb begin
    case (phase_r)
      PH_A:    piece = len_a;
      PH_B:    piece = len_b;
      PH_C:    piece = len_c;
      default: piece = len_a;
    endcase
  end

  assign diff      = len_r - piece;
  assign usable    = (piece != '0) && (piece <= len_r);
  assign mem_raddr = AW'(diff);
  assign best      = mpotl_pkg::max3(cand_a_r, cand_b_r, mpotl_pkg::cand(use_r, mem_rdata));
  assign src       = fwd_valid_r ? fwd_data_r : mem_rdata;
  assign in_range  = 32'(target) <= 32'(MAX_LENGTH);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    tgt_nxt       = tgt_r;
    use_nxt       = use_r;
    cand_a_nxt    = cand_a_r;
    cand_b_nxt    = cand_b_r;
    fwd_valid_nxt = 1'b0;
    fwd_data_nxt  = fwd_data_r;
    count_nxt     = count_r;
    possible_nxt  = possible_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = mpotl_pkg::ENTRY_ZERO_LEN;
    case (state_r)
      IDLE: begin
        if (start) begin
          tgt_nxt = target;
          if (!in_range) begin
            count_nxt    = '0;
            possible_nxt = 1'b0;
            state_nxt    = DONE;
          end else if (target == '0) begin
            count_nxt    = '0;
            possible_nxt = 1'b1;
            state_nxt    = DONE;
          end else begin
            // Seed length zero, then fill from length one
            mem_we    = 1'b1;
            len_nxt   = LW'(1);
            phase_nxt = PH_A;
            state_nxt = FILL;
          end
        end
      end
      FILL: begin
        use_nxt = usable;
        case (phase_r)
          PH_A: begin
            if (len_r != LW'(1)) begin
              // Retire the previous length; forward it if read back now
              mem_we        = 1'b1;
              mem_waddr     = AW'(len_r - LW'(1));
              mem_wdata     = best;
              fwd_valid_nxt = (len_a == LW'(1));
              fwd_data_nxt  = best;
            end
            phase_nxt = PH_B;
          end
          PH_B: begin
            cand_a_nxt = mpotl_pkg::cand(use_r, src);
            phase_nxt  = PH_C;
          end
          PH_C: begin
            cand_b_nxt = mpotl_pkg::cand(use_r, mem_rdata);
            phase_nxt  = PH_A;
            if (len_r == tgt_r) begin
              state_nxt = FINISH;
            end else begin
              len_nxt = len_r + LW'(1);
            end
          end
          default: phase_nxt = PH_A;
        endcase
      end
      FINISH: begin
        count_nxt    = best[LW-1:0];
        possible_nxt = best[LW];
        state_nxt    = DONE;
      end
      DONE: begin
        if (res_take) begin
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      phase_r     <= PH_A;
      fwd_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      fwd_valid_r <= fwd_valid_nxt;
    end
    len_r      <= len_nxt;
    tgt_r      <= tgt_nxt;
    use_r      <= use_nxt;
    cand_a_r   <= cand_a_nxt;
    cand_b_r   <= cand_b_nxt;
    fwd_data_r <= fwd_data_nxt;
    count_r    <= count_nxt;
    possible_r <= possible_nxt;
  end

  assign stat.idle         = (state_r == IDLE);
  assign stat.res_valid    = (state_r == DONE);
  assign stat.res_count    = count_r;
  assign stat.res_possible = possible_r;

`ifndef ASSERT_OFF
  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FILL) |-> (len_r != '0) && (len_r <= tgt_r))
    else $error("fill length outside 1..target");

  a_fwd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_valid_r |-> (state_r == FILL) && (phase_r == PH_B))
    else $error("forwarded entry used outside its capture phase");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.res_valid && !res_take) |=> stat.res_valid && $stable(count_r)
      && $stable(possible_r))
    else $error("result dropped or changed before it was taken");

  a_count_impossible: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.res_valid && !possible_r) |-> (count_r == '0))
    else $error("impossible split with nonzero count");
`endif

endmodule

>>> rtl/core/max_pieces_of_three_lengths.sv
// Max pieces of three lengths: largest number of pieces of lengths
// piece_len_a/b/c that add up exactly to a requested target length.
//
// Channels: in_* carries a request (in_target_length) on valid/ready;
// out_* returns one result (out_piece_count, out_possible) per request on
// valid/ready; cfg_* writes the three piece lengths by index 0..2 (other
// indexes are dropped). Write configuration only while no request is open.
//
// Throughput: one request at a time. A request for target T > 0 walks
// lengths 1..T in turn, each with three reads of the single read port of
// the table memory; the write of a length overlaps the first read of the
// next one. Targets of 0 or above MAX_LENGTH finish without touching the
// table.
//
// Output: a result register holds the answer; the engine takes the next
// request as soon as its result has moved there, so a stalled receiver
// blocks at most one request in flight. Reset (rst_n low, synchronous)
// drops any open request and result and sets all piece lengths to 1.
// The table needs no clearing pass: each request rewrites every length it later reads.
module max_pieces_of_three_lengths #(
  parameter int MAX_LENGTH = mpotl_pkg::MAX_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mpotl_pkg::LEN_W-1:0]       in_target_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mpotl_pkg::LEN_W-1:0]       out_piece_count,
  output logic                              out_possible,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpotl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpotl_pkg::LEN_W-1:0]       cfg_wdata
);

  localparam int LW = mpotl_pkg::LEN_W;
  localparam int AW = $clog2(MAX_LENGTH + 1);

  logic [LW-1:0]         len_a_r, len_b_r, len_c_r;
  logic                  out_valid_r;
  logic [LW-1:0]         out_count_r;
  logic                  out_possible_r;

  mpotl_pkg::eng_stat_t  stat;
  logic                  res_take;
  logic                  start;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  mpotl_pkg::entry_t     mem_wdata;
  mpotl_pkg::entry_t     mem_rdata;

  // Accept a request whenever the engine is free
  assign in_ready  = stat.idle;
  assign start     = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Advance the result into the output register when it is empty or drains
  assign res_take = stat.res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_a_r     <= LW'(1);
      len_b_r     <= LW'(1);
      len_c_r     <= LW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mpotl_pkg::REG_PIECE_LEN_A: len_a_r <= cfg_wdata;
          mpotl_pkg::REG_PIECE_LEN_B: len_b_r <= cfg_wdata;
          mpotl_pkg::REG_PIECE_LEN_C: len_c_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_take) begin
      out_count_r    <= stat.res_count;
      out_possible_r <= stat.res_possible;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_piece_count = out_count_r;
  assign out_possible    = out_possible_r;

  mpotl_engine #(
    .MAX_LENGTH (MAX_LENGTH),
    .AW         (AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .target    (in_target_length),
    .len_a     (len_a_r),
    .len_b     (len_b_r),
    .len_c     (len_c_r),
    .res_take  (res_take),
    .stat      (stat),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  mpotl_table_ram #(
    .MAX_LENGTH (MAX_LENGTH),
    .AW         (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
